// ===== src/dhbd_pkg.sv =====
package dhbd_pkg;

	localparam int FRAME_SIDE            = 640;
	localparam int SIGMOID_TABLE_ENTRIES = 256;

	localparam int IDX_W    = $clog2(SIGMOID_TABLE_ENTRIES);
	localparam int FRAC_W   = 14;
	localparam int POS_W    = FRAC_W + IDX_W;
	localparam int SIG_W    = 17;
	localparam int OUT_W    = 27;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [SIG_W-1:0] ONE_Q16 = SIG_W'(65536);
	localparam logic [OUT_W-1:0] OUT_MAX = '1;

	localparam logic [6:0] CH_X = 7'd0;
	localparam logic [6:0] CH_Y = 7'd1;
	localparam logic [6:0] CH_W = 7'd2;
	localparam logic [6:0] CH_H = 7'd3;

	localparam logic [1:0] LVL_MAX  = 2'd2;
	localparam logic [1:0] SLOT_MAX = 2'd2;

	localparam logic [15:0] GRID_TAB [3] = '{
		16'(FRAME_SIDE / 8), 16'(FRAME_SIDE / 16), 16'(FRAME_SIDE / 32)
	};

	localparam logic [8:0] ANCHOR_TAB [18] = '{
		9'd10,  9'd13,  9'd16,  9'd30,  9'd33,  9'd23,
		9'd30,  9'd61,  9'd62,  9'd45,  9'd59,  9'd119,
		9'd116, 9'd90,  9'd156, 9'd198, 9'd373, 9'd326
	};

	typedef enum logic [1:0] {
		KIND_CENTRE,
		KIND_SIZE,
		KIND_SCORE
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [6:0] grid;
		logic [1:0] lvl;
		logic [8:0] anchor;
		logic       err;
	} ctl_t;

	typedef struct packed {
		logic              sat;
		logic              neg;
		logic [IDX_W-1:0]  idx;
		logic [FRAC_W-1:0] frac;
		ctl_t              ctl;
	} fe_t;

	typedef logic [SIG_W-1:0] sig_tab_t [SIGMOID_TABLE_ENTRIES];

	// Shift-and-subtract quotient, used only while building the tables
	function automatic longint unsigned udiv64(input longint unsigned num,
			input longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// e^-x, x and result in Q.30, truncated Taylor series
	function automatic longint unsigned exp_neg_q30(input longint unsigned x);
		longint          sum;
		longint unsigned term;
		sum  = 0;
		term = 64'd1 << 30;
		for (int k = 0; k < 20; k++) begin
			if (k[0])
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
			term = udiv64((term * x) >> 30, 64'(k + 1));
		end
		if (sum < 0)
			sum = 0;
		return 64'(sum);
	endfunction

	// Sigmoid points at 16*j/N; hi_side shifts the table by one point
	function automatic sig_tab_t build_sig_tab(input bit hi_side);
		sig_tab_t        tab;
		longint unsigned x;
		longint unsigned e;
		longint unsigned d;
		longint unsigned j;
		for (int i = 0; i < SIGMOID_TABLE_ENTRIES; i++) begin
			j = 64'(i) + (hi_side ? 64'd1 : 64'd0);
			x = (j << 30) / 64'(SIGMOID_TABLE_ENTRIES);
			e = exp_neg_q30(x);
			for (int r = 0; r < 4; r++)
				e = (e * e + (64'd1 << 29)) >> 30;
			d = (64'd1 << 30) + e;
			tab[i] = SIG_W'(udiv64((64'd1 << 46) + (d >> 1), d));
		end
		return tab;
	endfunction

	localparam sig_tab_t SIG_LO_TAB = build_sig_tab(1'b0);
	localparam sig_tab_t SIG_HI_TAB = build_sig_tab(1'b1);

endpackage

// ===== src/dhbd_front.sv =====
module dhbd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] raw_logit,
	input  logic [6:0]         channel,
	input  logic [1:0]         anchor_slot,
	input  logic [6:0]         grid_x,
	input  logic [6:0]         grid_y,
	input  logic [1:0]         scale_level,
	output logic               q_push,
	input  logic               q_full,
	output dhbd_pkg::fe_t      q_wdata
);

	logic [15:0]               mag;
	logic [dhbd_pkg::POS_W-1:0] pos;
	logic [1:0]                lvl;
	logic [1:0]                slot;
	logic [4:0]                anc_idx;
	dhbd_pkg::fe_t             fe;
	dhbd_pkg::fe_t             fe_s1;
	logic                      v_s1;
	logic                      adv;

	always_comb begin
		mag  = raw_logit[15] ? 16'(16'd0 - raw_logit) : 16'(raw_logit);
		pos  = dhbd_pkg::POS_W'(mag[13:0]) *
		       dhbd_pkg::POS_W'(dhbd_pkg::SIGMOID_TABLE_ENTRIES);
		lvl  = (scale_level > dhbd_pkg::LVL_MAX) ? dhbd_pkg::LVL_MAX : scale_level;
		slot = (anchor_slot > dhbd_pkg::SLOT_MAX) ? dhbd_pkg::SLOT_MAX : anchor_slot;
		anc_idx = ({3'd0, lvl} * 5'd6) + {2'd0, slot, 1'b0} + {4'd0, channel[0]};

		fe.sat  = mag[15] | mag[14];
		fe.neg  = raw_logit[15];
		fe.idx  = pos[dhbd_pkg::FRAC_W +: dhbd_pkg::IDX_W];
		fe.frac = pos[dhbd_pkg::FRAC_W-1:0];
		unique case (channel) inside
			dhbd_pkg::CH_X, dhbd_pkg::CH_Y: fe.ctl.kind = dhbd_pkg::KIND_CENTRE;
			dhbd_pkg::CH_W, dhbd_pkg::CH_H: fe.ctl.kind = dhbd_pkg::KIND_SIZE;
			default:                        fe.ctl.kind = dhbd_pkg::KIND_SCORE;
		endcase
		fe.ctl.grid   = channel[0] ? grid_y : grid_x;
		fe.ctl.lvl    = lvl;
		fe.ctl.anchor = dhbd_pkg::ANCHOR_TAB[anc_idx];
		fe.ctl.err    = (16'(grid_x) >= dhbd_pkg::GRID_TAB[lvl]) ||
		                (16'(grid_y) >= dhbd_pkg::GRID_TAB[lvl]);
	end

	assign full    = v_s1 && q_full;
	assign adv     = !full;
	assign q_push  = v_s1 && !q_full;
	assign q_wdata = fe_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && push) begin
			fe_s1 <= fe;
		end
	end

endmodule

// ===== src/dhbd_fifo.sv =====
module dhbd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  dhbd_pkg::fe_t wdata,
	input  logic          pop,
	output logic          empty,
	output dhbd_pkg::fe_t rdata
);

	localparam int PTR_W = $clog2(dhbd_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(dhbd_pkg::QUEUE_DEPTH + 1);

	dhbd_pkg::fe_t    mem_q [dhbd_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = cnt_q == CNT_W'(dhbd_pkg::QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign do_wr = push && !full;
	assign do_rd = pop && !empty;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wr_q <= (wr_q == PTR_W'(dhbd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_rd)
				rd_q <= (rd_q == PTR_W'(dhbd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_q] <= wdata;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(dhbd_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		do_wr && !do_rd |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count missed a write");
	a_cnt_down: assert property (@(posedge clk) disable iff (!arst_n)
		do_rd && !do_wr |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("queue count missed a read");
`endif

endmodule

// ===== src/dhbd_back.sv =====
module dhbd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	output logic                          q_pop,
	input  dhbd_pkg::fe_t                 q_rdata,
	output logic                          empty,
	input  logic                          pop,
	output logic [dhbd_pkg::OUT_W-1:0]    decoded_value,
	output logic                          range_error
);

	localparam int SW = dhbd_pkg::SIG_W;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en;

	dhbd_pkg::ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;

	logic [SW-1:0]              lo_s1, diff_s1, lo_s2;
	logic [dhbd_pkg::FRAC_W-1:0] frac_s1;
	logic                       sat_s1, neg_s1, sat_s2, neg_s2;
	logic [30:0]                prod_s2;
	logic [SW-1:0]              sig_s3, sig_s4, sig_s5;
	logic [35:0]                sq_s4;
	logic [28:0]                cen_s4, cen_s5;
	logic [43:0]                area_s5;
	logic [dhbd_pkg::OUT_W-1:0] dec_s6;
	logic                       err_s6;

	logic [SW-1:0] lo_c, hi_c;
	logic [SW:0]   interp;
	logic [SW-1:0] sig_c;
	logic [17:0]   two_s;
	logic [23:0]   cen_base;
	logic [27:0]   area_rnd;
	logic [dhbd_pkg::OUT_W-1:0] dec_c;

	assign en    = !v_s6 || pop;
	assign q_pop = en && !q_empty;
	assign empty = !v_s6;
	assign decoded_value = dec_s6;
	assign range_error   = err_s6;

	always_comb begin
		lo_c = dhbd_pkg::SIG_LO_TAB[q_rdata.idx];
		hi_c = dhbd_pkg::SIG_HI_TAB[q_rdata.idx];
		if (hi_c < lo_c)
			hi_c = lo_c;

		interp = {1'b0, lo_s2} + (SW + 1)'((32'(prod_s2) + 32'd8192) >> 14);
		sig_c  = (interp > {1'b0, dhbd_pkg::ONE_Q16}) ? dhbd_pkg::ONE_Q16 : interp[SW-1:0];
		if (sat_s2)
			sig_c = dhbd_pkg::ONE_Q16;
		if (neg_s2)
			sig_c = dhbd_pkg::ONE_Q16 - sig_c;

		two_s    = {sig_s3, 1'b0};
		cen_base = {1'b0, ctl_s3.grid, 16'd0} + 24'(two_s);

		area_rnd = 28'((area_s5 + 44'd32768) >> 16);
		case (ctl_s5.kind)
			dhbd_pkg::KIND_CENTRE:
				dec_c = (cen_s5 > 29'(dhbd_pkg::OUT_MAX)) ? dhbd_pkg::OUT_MAX : cen_s5[26:0];
			dhbd_pkg::KIND_SIZE:
				dec_c = (area_rnd > 28'(dhbd_pkg::OUT_MAX)) ? dhbd_pkg::OUT_MAX : area_rnd[26:0];
			default:
				dec_c = dhbd_pkg::OUT_W'(sig_s5);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// advance the whole pipe together; a stalled result holds every stage
	always_ff @(posedge clk) begin
		if (en) begin
			lo_s1   <= lo_c;
			diff_s1 <= hi_c - lo_c;
			frac_s1 <= q_rdata.frac;
			sat_s1  <= q_rdata.sat;
			neg_s1  <= q_rdata.neg;
			ctl_s1  <= q_rdata.ctl;

			prod_s2 <= 31'(diff_s1) * 31'(frac_s1);
			lo_s2   <= lo_s1;
			sat_s2  <= sat_s1;
			neg_s2  <= neg_s1;
			ctl_s2  <= ctl_s1;

			sig_s3  <= sig_c;
			ctl_s3  <= ctl_s2;

			sq_s4   <= 36'(two_s) * 36'(two_s);
			cen_s4  <= 29'({cen_base, 3'b000}) << ctl_s3.lvl;
			sig_s4  <= sig_s3;
			ctl_s4  <= ctl_s3;

			area_s5 <= 44'(sq_s4) * 44'(ctl_s4.anchor);
			cen_s5  <= cen_s4;
			sig_s5  <= sig_s4;
			ctl_s5  <= ctl_s4;

			dec_s6  <= dec_c;
			err_s6  <= ctl_s5.err;
		end
	end

`ifndef SYNTHESIS
	a_sig_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> sig_s3 <= dhbd_pkg::ONE_Q16)
		else $error("sigmoid above one");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s6 && !pop |=> v_s1 && v_s6)
		else $error("item lost in stalled pipeline");
	a_no_pop_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && !pop |-> !q_pop)
		else $error("queue popped during stall");
`endif

endmodule

// ===== src/detection_head_box_decode_top.sv =====
// Throughput: one transaction per cycle while nothing stalls; the front register, a
// 4-entry queue and a 6-stage decode pipe (table lookup, interpolation, sigmoid,
// square, anchor scale, round) each take one item a cycle, and the decode pipe halts
// only while pop is low; the front halts while it holds an item and the queue is full.
// Reset: arst_n clears all valid and queue state at once; the block is empty after it.
module detection_head_box_decode_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic signed [15:0]         raw_logit,
	input  logic [6:0]                 channel,
	input  logic [1:0]                 anchor_slot,
	input  logic [6:0]                 grid_x,
	input  logic [6:0]                 grid_y,
	input  logic [1:0]                 scale_level,
	output logic                       empty,
	input  logic                       pop,
	output logic [dhbd_pkg::OUT_W-1:0] decoded_value,
	output logic                       range_error
);

	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_empty;
	dhbd_pkg::fe_t q_wdata;
	dhbd_pkg::fe_t q_rdata;

	dhbd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.raw_logit   (raw_logit),
		.channel     (channel),
		.anchor_slot (anchor_slot),
		.grid_x      (grid_x),
		.grid_y      (grid_y),
		.scale_level (scale_level),
		.q_push      (q_push),
		.q_full      (q_full),
		.q_wdata     (q_wdata)
	);

	dhbd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.full   (q_full),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	dhbd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.q_rdata       (q_rdata),
		.empty         (empty),
		.pop           (pop),
		.decoded_value (decoded_value),
		.range_error   (range_error)
	);

endmodule
